FILE: sv/atrp_pkg.sv
package atrp_pkg;

   localparam int ANGLE_TABLE_LEN = 24;
   // one result bit per root step: 60-bit radicand, 30-bit root
   localparam int SQRT_STEPS = 30;

   localparam logic signed [15:0] RIGHT_ANGLE = 16'sd23040;

   // register indexes on the csr port
   localparam logic [1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [1:0] CSR_OFFSET_Z = 2'd2;

   typedef logic signed [24:0] angle_acc_type;

   // atan(2^-i) in degrees, 16 fraction bits
   localparam angle_acc_type ATAN_TABLE [ANGLE_TABLE_LEN] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
      25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
      25'sd917,     25'sd458,     25'sd229,    25'sd115,
      25'sd57,      25'sd29,      25'sd14,     25'sd7,
      25'sd4,       25'sd2,       25'sd1,      25'sd0
   };

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } accel_in_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
   } tilt_out_type;

endpackage

FILE: sv/accel_tilt_roll_pitch_core.sv
// Tilt from one accelerometer sample: each axis gets its offset register times 64 added
// (wrapping to 16 bits), then roll = atan(Y / sqrt(X^2+Z^2)) and pitch = atan(-X / sqrt(Y^2+Z^2))
// come out in 1/256 degree, clamped to +/-90 degrees. The block takes one sample per clock while
// a stage is free or the result is taken, and returns one word per sample, in order. Offset add,
// square and sum take three stages, the bit-per-stage square root thirty, the CORDIC vectoring
// one stage per rotation (at most 24), and the rounding logic feeds the output register.
// Stalls on the result side fill bubbles first, so input is still taken while a result waits
// as long as an empty stage remains. Offsets reset to zero and are written on the csr port,
// which is always ready; writes to an index past offset_z are ignored.
module accel_tilt_roll_pitch_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  atrp_pkg::accel_in_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output atrp_pkg::tilt_out_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data
);
   import atrp_pkg::*;

   localparam int NCORD = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES : ANGLE_TABLE_LEN;
   localparam int S_SQR = 3;
   localparam int S_COR = S_SQR + SQRT_STEPS;
   localparam int S_OUT = S_COR + NCORD;
   localparam int NS    = S_OUT + 1;

   typedef struct packed {
      logic [31:0]        rad;
      logic [31:0]        rem;
      logic [29:0]        root;
      logic signed [16:0] num;
   } root_lane_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      angle_acc_type      z;
      logic               special;
      logic signed [15:0] fixed_angle;
   } rot_lane_type;

   // one digit of the floor square root
   function automatic root_lane_type root_step(input root_lane_type a);
      logic [33:0]   part;
      logic [33:0]   trial;
      root_lane_type r;
      part  = {a.rem, a.rad[31:30]};
      trial = {2'b00, a.root, 2'b01};
      r     = a;
      r.rad = {a.rad[29:0], 2'b00};
      if (part >= trial) begin
         r.rem  = 32'(part - trial);
         r.root = {a.root[28:0], 1'b1};
      end else begin
         r.rem  = part[31:0];
         r.root = {a.root[28:0], 1'b0};
      end
      return r;
   endfunction

   function automatic rot_lane_type rot_step(input rot_lane_type a, input int i);
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      rot_lane_type       r;
      xs = a.x >>> i;
      ys = a.y >>> i;
      r  = a;
      if (!a.y[33]) begin
         r.x = a.x + ys;
         r.y = a.y - xs;
         r.z = a.z + ATAN_TABLE[i];
      end else begin
         r.x = a.x - ys;
         r.y = a.y + xs;
         r.z = a.z - ATAN_TABLE[i];
      end
      return r;
   endfunction

   // round half up to 1/256 degree and clamp
   function automatic logic signed [15:0] finish(input rot_lane_type a);
      logic signed [25:0] zr;
      logic signed [17:0] q;
      logic signed [15:0] res;
      zr = {a.z[24], a.z} + 26'sd128;
      q  = zr[25:8];
      if (a.special) begin
         res = a.fixed_angle;
      end else if (q > 18'sd23040) begin
         res = RIGHT_ANGLE;
      end else if (q < -18'sd23040) begin
         res = -RIGHT_ANGLE;
      end else begin
         res = q[15:0];
      end
      return res;
   endfunction

   // offset registers
   logic signed [7:0] off_x_ff, off_y_ff, off_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_X: off_x_ff <= csr_data;
            CSR_OFFSET_Y: off_y_ff <= csr_data;
            CSR_OFFSET_Z: off_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage valids; a stage moves when it or any later stage is empty or the output is taken
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] vld_prev;
   logic [NS-1:0] adv;

   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = rsp_ready | ~(&vld_ff[NS-1:k]);
   end

   assign vld_prev = {vld_ff[NS-2:0], req_valid};
   assign vld_in   = (vld_prev & adv) | (vld_ff & ~adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NS-1];

   // stage 0: offset correction
   logic signed [15:0] cx_in, cy_in, cz_in;
   logic signed [15:0] cx_ff, cy_ff, cz_ff;

   assign cx_in = req_data.accel_x + {{2{off_x_ff[7]}}, off_x_ff, 6'b0};
   assign cy_in = req_data.accel_y + {{2{off_y_ff[7]}}, off_y_ff, 6'b0};
   assign cz_in = req_data.accel_z + {{2{off_z_ff[7]}}, off_z_ff, 6'b0};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   // stage 1: squares and numerators
   logic signed [31:0] xx_in, yy_in, zz_in;
   logic [30:0]        xx_ff, yy_ff, zz_ff;
   logic signed [16:0] num_roll_ff, num_pitch_ff;

   assign xx_in = cx_ff * cx_ff;
   assign yy_in = cy_ff * cy_ff;
   assign zz_in = cz_ff * cz_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         xx_ff        <= xx_in[30:0];
         yy_ff        <= yy_in[30:0];
         zz_ff        <= zz_in[30:0];
         num_roll_ff  <= {cy_ff[15], cy_ff};
         // -(-32768) kept as +32768
         num_pitch_ff <= 17'sd0 - {cx_ff[15], cx_ff};
      end
   end

   // stage 2: sums of squares
   logic [31:0]        sum_roll_ff, sum_pitch_ff;
   logic signed [16:0] num_roll2_ff, num_pitch2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sum_roll_ff   <= {1'b0, xx_ff} + {1'b0, zz_ff};
         sum_pitch_ff  <= {1'b0, yy_ff} + {1'b0, zz_ff};
         num_roll2_ff  <= num_roll_ff;
         num_pitch2_ff <= num_pitch_ff;
      end
   end

   // square root stages, lane 0 roll, lane 1 pitch
   root_lane_type root_src [2];
   root_lane_type rt_ff [SQRT_STEPS][2];

   assign root_src[0] = '{rad: sum_roll_ff, rem: '0, root: '0, num: num_roll2_ff};
   assign root_src[1] = '{rad: sum_pitch_ff, rem: '0, root: '0, num: num_pitch2_ff};

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
      for (genvar l = 0; l < 2; l++) begin : g_lane
         root_lane_type src;
         if (j == 0) begin : g_first
            assign src = root_src[l];
         end else begin : g_next
            assign src = rt_ff[j-1][l];
         end
         always_ff @(posedge clock) begin
            if (adv[S_SQR+j]) begin
               rt_ff[j][l] <= root_step(src);
            end
         end
      end
   end

   // cordic vectoring stages
   rot_lane_type rot_src [2];
   rot_lane_type cr_ff [NCORD][2];

   for (genvar l = 0; l < 2; l++) begin : g_entry
      root_lane_type fin;
      assign fin = rt_ff[SQRT_STEPS-1][l];
      always_comb begin
         rot_src[l].x       = {4'b0000, fin.root};
         rot_src[l].y       = {{3{fin.num[16]}}, fin.num, 14'b0};
         rot_src[l].z       = '0;
         // zero root only when both squares are zero
         rot_src[l].special = (fin.root == '0);
         if (fin.num[16]) begin
            rot_src[l].fixed_angle = -RIGHT_ANGLE;
         end else if (fin.num != '0) begin
            rot_src[l].fixed_angle = RIGHT_ANGLE;
         end else begin
            rot_src[l].fixed_angle = '0;
         end
      end
   end

   for (genvar i = 0; i < NCORD; i++) begin : g_cordic
      for (genvar l = 0; l < 2; l++) begin : g_lane
         rot_lane_type src;
         if (i == 0) begin : g_first
            assign src = rot_src[l];
         end else begin : g_next
            assign src = cr_ff[i-1][l];
         end
         always_ff @(posedge clock) begin
            if (adv[S_COR+i]) begin
               cr_ff[i][l] <= rot_step(src, i);
            end
         end
      end
   end

   // output register
   tilt_out_type out_ff;

   always_ff @(posedge clock) begin
      if (adv[S_OUT]) begin
         out_ff.roll_angle  <= finish(cr_ff[NCORD-1][0]);
         out_ff.pitch_angle <= finish(cr_ff[NCORD-1][1]);
      end
   end

   assign rsp_data = out_ff;

endmodule

FILE: sv/atrp_checker.sv
module atrp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input atrp_pkg::tilt_out_type rsp_data
);
   import atrp_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.roll_angle <= RIGHT_ANGLE && rsp_data.roll_angle >= -RIGHT_ANGLE
         && rsp_data.pitch_angle <= RIGHT_ANGLE && rsp_data.pitch_angle >= -RIGHT_ANGLE)
      else $error("angle beyond ninety degrees");

   // input is refused only when every stage is full and the output is stalled
   a_ready_back: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused while output drains");

endmodule

bind accel_tilt_roll_pitch_core atrp_checker u_atrp_checker (.*);

FILE: bench/tb_accel_tilt_roll_pitch_core.sv
`timescale 1ns / 100ps

module tb_accel_tilt_roll_pitch_core;

   import atrp_pkg::*;

   localparam int CORDIC_STAGES = 16;
   localparam int PIPE_LATENCY  = 34 + CORDIC_STAGES;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 100;
   localparam int RANDOM_PHASES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int ANGLE_CLAMP   = 23040;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // atan(2^-i) in degrees with 16 fraction bits
   localparam longint ATAN_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   localparam int SEND_IDLE [3] = '{25, 64, 0};
   localparam int RECV_IDLE [3] = '{64, 25, 0};

   typedef struct packed {
      logic signed [7:0]  ox;
      logic signed [7:0]  oy;
      logic signed [7:0]  oz;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      bit                 roll_known;
      bit                 pitch_known;
      logic signed [15:0] roll_val;
      logic signed [15:0] pitch_val;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;

   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 1'b0, 16'sd23040, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0, -16'sd23040, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'sd0, -16'sd23040},
      // negated X of -32768 must stay positive
      '{8'h00, 8'h00, 8'h00, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'sd0, 16'sd23040},
      '{8'h00, 8'h00, 8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h5555, 16'hAAAA, 16'h00FF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'hAAAA, 16'h5555, 16'hFF00, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h03E8, 16'hFC18, 16'h0000, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h00, 16'h0000, 16'h0001, 16'h0000, 1'b1, 1'b0, 16'sd23040, 16'sd0},
      // offsets that push every axis past the 16-bit range
      '{8'h7F, 8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{8'h80, 8'h80, 8'h80, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'sd0, 16'sd0},
      // offset cancels the reading exactly
      '{8'h80, 8'h00, 8'h00, 16'h2000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'sd0, 16'sd0},
      '{8'h80, 8'h00, 8'h00, 16'h2001, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'sd0, -16'sd23040},
      '{8'h00, 8'h40, 8'h00, 16'h0000, 16'hF000, 16'h0000, 1'b1, 1'b1, 16'sd0, 16'sd0},
      '{8'h00, 8'h00, 8'h7F, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'sd0, 16'sd0}
   };

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   accel_in_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   tilt_out_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [7:0]   csr_data  = '0;

   logic signed [7:0] offset_model [3] = '{8'sd0, 8'sd0, 8'sd0};
   tilt_out_type      pending_tilt [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int fail_count    = 0;
   int words_checked = 0;
   int samples_sent  = 0;
   int offset_sets   = 0;

   accel_tilt_roll_pitch_core #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_tilt.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [15:0] corrected_axis(logic signed [15:0] raw,
                                                          logic signed [7:0] off);
      logic signed [15:0] scaled;
      scaled = {{2{off[7]}}, off, 6'b0};
      return raw + scaled;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned rbit;
      res  = 0;
      rbit = 64'd1 << 62;
      while (rbit > v) rbit >>= 2;
      while (rbit != 0) begin
         if (v >= res + rbit) begin
            v   = v - (res + rbit);
            res = (res >> 1) + rbit;
         end else begin
            res = res >> 1;
         end
         rbit >>= 2;
      end
      return res;
   endfunction

   // atan(num / sqrt(a^2 + b^2)) in 1/256 degree
   function automatic logic signed [15:0] tilt_angle(int num, int a, int b);
      longint unsigned sq_sum;
      longint xr, yr, zr, xs, ys, q;
      sq_sum = longint'(a) * a + longint'(b) * b;
      xr     = longint'(root_floor(sq_sum << 28));
      yr     = longint'(num) * 16384;
      zr     = 0;
      if (xr == 0) begin
         if (num > 0) return 16'(ANGLE_CLAMP);
         if (num < 0) return 16'(-ANGLE_CLAMP);
         return 16'sd0;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         xs = xr >>> i;
         ys = yr >>> i;
         if (yr >= 0) begin
            xr = xr + ys;
            yr = yr - xs;
            zr = zr + ATAN_Q16[i];
         end else begin
            xr = xr - ys;
            yr = yr + xs;
            zr = zr - ATAN_Q16[i];
         end
      end
      q = (zr + 128) >>> 8;
      if (q > ANGLE_CLAMP) q = ANGLE_CLAMP;
      if (q < -ANGLE_CLAMP) q = -ANGLE_CLAMP;
      return 16'(q);
   endfunction

   function automatic tilt_out_type predict_tilt(accel_in_type s);
      int cx, cy, cz;
      tilt_out_type r;
      cx            = corrected_axis(s.accel_x, offset_model[0]);
      cy            = corrected_axis(s.accel_y, offset_model[1]);
      cz            = corrected_axis(s.accel_z, offset_model[2]);
      r.roll_angle  = tilt_angle(cy, cx, cz);
      r.pitch_angle = tilt_angle(-cx, cy, cz);
      return r;
   endfunction

   // corner values half the time, otherwise random, with offset-cancelling readings to hit zero denominators
   function automatic logic signed [15:0] random_axis(logic signed [7:0] off);
      logic signed [15:0] v;
      int t;
      case ($urandom_range(0, 7))
         0: v = 16'sd0;
         1: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         2: begin
            t = $urandom_range(0, 126);
            v = 16'(t - 63);
         end
         3: v = -{{2{off[7]}}, off, 6'b0};
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_sample(input accel_in_type s, input tilt_out_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_tilt.push_back(want);
      samples_sent++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         atrp_pkg::CSR_OFFSET_X: offset_model[0] = value;
         atrp_pkg::CSR_OFFSET_Y: offset_model[1] = value;
         atrp_pkg::CSR_OFFSET_Z: offset_model[2] = value;
         default: ;
      endcase
   endtask

   task automatic load_offsets(input logic [7:0] ox, input logic [7:0] oy, input logic [7:0] oz);
      csr_write(atrp_pkg::CSR_OFFSET_X, ox);
      csr_write(atrp_pkg::CSR_OFFSET_Y, oy);
      csr_write(atrp_pkg::CSR_OFFSET_Z, oz);
      // writes past the last register must leave the offsets alone
      csr_write(CSR_SPARE, 8'($urandom));
      csr_valid <= 1'b0;
      offset_sets++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_tilt.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      tilt_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tilt.size() == 0) begin
            $error("tilt word %0d/%0d arrived with nothing outstanding",
                   rsp_data.roll_angle, rsp_data.pitch_angle);
            fail_count++;
         end else begin
            want = pending_tilt.pop_front();
            words_checked++;
            if (rsp_data.roll_angle !== want.roll_angle) begin
               $error("roll_angle: expected %0d, got %0d", want.roll_angle,
                      rsp_data.roll_angle);
               fail_count++;
            end
            if (rsp_data.pitch_angle !== want.pitch_angle) begin
               $error("pitch_angle: expected %0d, got %0d", want.pitch_angle,
                      rsp_data.pitch_angle);
               fail_count++;
            end
         end
      end
      // long hold-off so the pipeline fills and backs up the input
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      directed_row_type row;
      accel_in_type     smp;
      tilt_out_type     want;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         if (row.ox != offset_model[0] || row.oy != offset_model[1] ||
             row.oz != offset_model[2]) begin
            settle();
            load_offsets(row.ox, row.oy, row.oz);
         end
         smp.accel_x = row.ax;
         smp.accel_y = row.ay;
         smp.accel_z = row.az;
         want        = predict_tilt(smp);
         if (row.roll_known) want.roll_angle = row.roll_val;
         if (row.pitch_known) want.pitch_angle = row.pitch_val;
         send_sample(smp, want);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            1: load_offsets(8'h7F, 8'h80, 8'h7F);
            2: load_offsets(8'h80, 8'h7F, 8'h80);
            default: load_offsets(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         send_idle_pct = SEND_IDLE[p % 3];
         recv_idle_pct = RECV_IDLE[p % 3];
         if (p == 2) hold_seq <= hold_seq + 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            smp.accel_x = random_axis(offset_model[0]);
            smp.accel_y = random_axis(offset_model[1]);
            smp.accel_z = random_axis(offset_model[2]);
            send_sample(smp, predict_tilt(smp));
         end
      end

      settle();
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("%0d samples sent, %0d tilt words checked, %0d offset settings loaded",
               samples_sent, words_checked, offset_sets);
      $display("%0d mismatches in %0d cycles", fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
